FILE: hw/rtl/rtv_pkg.sv
// Shared types and constants of the ribbon trail vertex generator.
`default_nettype none
package rtv_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W        = 32;
    localparam int HW_W           = 24;
    localparam int ALONG_W        = 16;
    localparam logic [HW_W-1:0] HALF_WIDTH_RST = 24'd65536;

    // multiplier operand selections
    localparam logic [3:0] MI_L1C2      = 4'd0;
    localparam logic [3:0] MI_L2C1      = 4'd1;
    localparam logic [3:0] MI_L2C0      = 4'd2;
    localparam logic [3:0] MI_L0C2      = 4'd3;
    localparam logic [3:0] MI_L0C1      = 4'd4;
    localparam logic [3:0] MI_L1C0      = 4'd5;
    localparam logic [3:0] MI_SQ_FIRST  = 4'd6;
    localparam logic [3:0] MI_SQ_LAST   = 4'd8;
    localparam logic [3:0] MI_DIV_FIRST = 4'd9;
    localparam logic [3:0] MI_DIV_LAST  = 4'd11;

    localparam logic [4:0] SQRT_LAST_STEP = 5'd30;
    localparam logic [4:0] DIV_LAST_STEP  = 5'd24;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_LINE, OP_MUL, OP_ACC, OP_MAG, OP_NORM, OP_ZERO,
        OP_SQINIT, OP_SQSTEP, OP_DIVSTEP, OP_DIVEND, OP_VTX, OP_ADV
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] idx;
        logic       side;
    } t_dp_cmd;

    typedef struct packed {
        logic zero;
        logic norm_ok;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/rtv_if.sv
// Item channels: trail point input and ribbon vertex output.
`default_nettype none
interface rtv_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    modport source (output valid, cmd, pos_x, pos_y, pos_z, cam_x, cam_y, cam_z,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, pos_z, cam_x, cam_y, cam_z,
                  output ready);
endinterface

interface rtv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [15:0]        along;
    logic               side;
    logic               last;
    modport source (output valid, vert_x, vert_y, vert_z, along, side, last,
                    input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, along, side, last,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rtv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rtv_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rtv_dp.sv
// Arm and vertex datapath: cross product, normalisation, square root, division.
`default_nettype none
module rtv_dp import rtv_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_dp_cmd                   i_cmd,
    input  wire logic [HW_W-1:0]           i_half_width,
    input  wire logic signed [COORD_W-1:0] i_pos [3],
    input  wire logic signed [COORD_W-1:0] i_cam [3],
    input  wire logic [3*COORD_W-1:0]      i_rdata,
    output t_dp_sts                        o_sts,
    output logic signed [COORD_W-1:0]      o_vert [3]
);
    logic signed [COORD_W-1:0] r_cur [3];
    logic signed [COORD_W-1:0] r_next [3];
    logic signed [30:0]        r_l [3];
    logic signed [30:0]        r_c [3];
    logic signed [63:0]        r_prod;
    logic signed [63:0]        r_acc;
    logic signed [61:0]        r_x [3];
    logic [61:0]               r_m [3];
    logic                      r_neg [3];
    logic [61:0]               r_sum;
    logic [61:0]               r_sx;
    logic [61:0]               r_sr;
    logic [60:0]               r_sbit;
    logic [55:0]               r_rem;
    logic [55:0]               r_dv;
    logic [24:0]               r_q;
    logic signed [25:0]        r_arm [3];
    logic signed [COORD_W-1:0] r_vert [3];

    logic signed [31:0] mul_a, mul_b;
    logic signed [32:0] cam33 [3];
    logic [1:0]         sh_line, sh_cam;
    logic               any_ge38, any_ge30, all_lt21, all_lt29, all_zero;
    logic [61:0]        sq_t;
    logic [1:0]         k_div;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] u;
        u = v;
        return v[32] ? (~u + 33'd1) : u;
    endfunction

    // common right shift that brings the largest magnitude below 2^30
    function automatic logic [1:0] shrink_amt(input logic signed [32:0] a,
                                              input logic signed [32:0] b,
                                              input logic signed [32:0] c);
        logic [32:0] t;
        t = mag33(a) | mag33(b) | mag33(c);
        if (t[32])      return 2'd3;
        else if (t[31]) return 2'd2;
        else if (t[30]) return 2'd1;
        else            return 2'd0;
    endfunction

    function automatic logic signed [30:0] shrink(input logic signed [32:0] v,
                                                  input logic [1:0] s);
        logic [32:0] q;
        q = mag33(v) >> s;
        return v[32] ? -$signed(q[30:0]) : $signed(q[30:0]);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647)       return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cam33[k] = {i_cam[k][COORD_W-1], i_cam[k]};
        end
    end
    // LINE reads the ring data, so the line is formed from it directly
    logic signed [COORD_W-1:0] rd_pt [3];
    logic signed [32:0]        line_rd [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rd_pt[k]   = i_rdata[k*COORD_W +: COORD_W];
            line_rd[k] = {rd_pt[k][COORD_W-1], rd_pt[k]} - {r_cur[k][COORD_W-1], r_cur[k]};
        end
        sh_line = shrink_amt(line_rd[0], line_rd[1], line_rd[2]);
        sh_cam  = shrink_amt(cam33[0], cam33[1], cam33[2]);
    end

    always_comb begin
        any_ge38 = 1'b0;
        any_ge30 = 1'b0;
        all_lt21 = 1'b1;
        all_lt29 = 1'b1;
        all_zero = 1'b1;
        for (int k = 0; k < 3; k++) begin
            any_ge38 = any_ge38 | (|r_m[k][61:38]);
            any_ge30 = any_ge30 | (|r_m[k][61:30]);
            all_lt21 = all_lt21 & ~(|r_m[k][61:21]);
            all_lt29 = all_lt29 & ~(|r_m[k][61:29]);
            all_zero = all_zero & ~(|r_m[k]);
        end
        o_sts.zero    = all_zero;
        o_sts.norm_ok = ~any_ge30 & ~all_lt29;
    end

    always_comb begin
        k_div = 2'(i_cmd.idx - MI_DIV_FIRST);
        case (i_cmd.idx)
            MI_L1C2: begin mul_a = 32'(r_l[1]); mul_b = 32'(r_c[2]); end
            MI_L2C1: begin mul_a = 32'(r_l[2]); mul_b = 32'(r_c[1]); end
            MI_L2C0: begin mul_a = 32'(r_l[2]); mul_b = 32'(r_c[0]); end
            MI_L0C2: begin mul_a = 32'(r_l[0]); mul_b = 32'(r_c[2]); end
            MI_L0C1: begin mul_a = 32'(r_l[0]); mul_b = 32'(r_c[1]); end
            MI_L1C0: begin mul_a = 32'(r_l[1]); mul_b = 32'(r_c[0]); end
            default: begin
                if (i_cmd.idx inside {[MI_SQ_FIRST:MI_SQ_LAST]}) begin
                    mul_a = $signed({2'b00, r_m[2'(i_cmd.idx - MI_SQ_FIRST)][29:0]});
                    mul_b = mul_a;
                end else begin
                    mul_a = $signed({2'b00, r_m[k_div][29:0]});
                    mul_b = $signed({8'd0, i_half_width});
                end
            end
        endcase
        sq_t = r_sr + 62'(r_sbit);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_cur[k] <= i_pos[k];
                    r_c[k]   <= shrink(cam33[k], sh_cam);
                end
            end
            OP_LINE: begin
                for (int k = 0; k < 3; k++) begin
                    r_next[k] <= rd_pt[k];
                    r_l[k]    <= shrink(line_rd[k], sh_line);
                end
            end
            OP_MUL: r_prod <= mul_a * mul_b;
            OP_ACC: begin
                case (i_cmd.idx)
                    MI_L1C2, MI_L2C0, MI_L0C1: r_acc <= r_prod;
                    MI_L2C1: r_x[0] <= 62'(r_acc - r_prod);
                    MI_L0C2: r_x[1] <= 62'(r_acc - r_prod);
                    MI_L1C0: r_x[2] <= 62'(r_acc - r_prod);
                    default: begin
                        if (i_cmd.idx inside {[MI_SQ_FIRST:MI_SQ_LAST]}) begin
                            r_sum <= r_sum + r_prod[61:0];
                        end else begin
                            r_rem <= {2'b00, r_prod[53:0]} + 56'(r_sr[30:1]);
                            r_dv  <= {1'b0, r_sr[30:0], 24'd0};
                            r_q   <= '0;
                        end
                    end
                endcase
            end
            OP_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k]   <= r_x[k][61] ? 62'(-r_x[k]) : r_x[k];
                    r_neg[k] <= r_x[k][61];
                end
                r_sum <= '0;
            end
            OP_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    if (any_ge38)      r_m[k] <= r_m[k] >> 8;
                    else if (any_ge30) r_m[k] <= r_m[k] >> 1;
                    else if (all_lt21) r_m[k] <= r_m[k] << 8;
                    else               r_m[k] <= r_m[k] << 1;
                end
            end
            OP_ZERO: begin
                for (int k = 0; k < 3; k++) r_arm[k] <= '0;
            end
            OP_SQINIT: begin
                r_sx   <= r_sum;
                r_sr   <= '0;
                r_sbit <= 61'd1 << 60;
            end
            OP_SQSTEP: begin
                if (r_sx >= sq_t) begin
                    r_sx <= r_sx - sq_t;
                    r_sr <= (r_sr >> 1) + 62'(r_sbit);
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            OP_DIVSTEP: begin
                if (r_rem >= r_dv) begin
                    r_rem <= r_rem - r_dv;
                    r_q   <= {r_q[23:0], 1'b1};
                end else begin
                    r_q   <= {r_q[23:0], 1'b0};
                end
                r_dv <= r_dv >> 1;
            end
            OP_DIVEND: begin
                r_arm[k_div] <= r_neg[k_div] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
            end
            OP_VTX: begin
                for (int k = 0; k < 3; k++) begin
                    if (i_cmd.side)
                        r_vert[k] <= sat(34'(r_cur[k]) - 34'(r_arm[k]));
                    else
                        r_vert[k] <= sat(34'(r_cur[k]) + 34'(r_arm[k]));
                end
            end
            OP_ADV: begin
                for (int k = 0; k < 3; k++) r_cur[k] <= r_next[k];
            end
            default: ;
        endcase
    end

    assign o_vert = r_vert;
endmodule
`default_nettype wire

FILE: hw/rtl/rtv_ctrl.sv
// Sequencer: history pointers, segment walk and datapath command issue.
`default_nettype none
module rtv_ctrl import rtv_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_cmd,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ALONG_W-1:0]                 o_along,
    output logic                               o_side,
    output logic                               o_last,
    input  wire t_dp_sts                       i_sts,
    output t_dp_cmd                            o_cmd,
    output logic                               o_we,
    output logic                               o_wzero,
    output logic [$clog2(MAX_POINTS)-1:0]      o_waddr,
    output logic                               o_re,
    output logic [$clog2(MAX_POINTS)-1:0]      o_raddr
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int RW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam logic [ALONG_W-1:0] STEP_Q = ALONG_W'(65536 / MAX_POINTS);
    localparam logic [RW-1:0]      STEP_R = RW'(65536 % MAX_POINTS);
    localparam logic [AW-1:0]      SLOT_TOP = AW'(MAX_POINTS - 1);
    localparam logic [CW-1:0]      CNT_MAX  = CW'(MAX_POINTS);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_RD   = 14'b00000000000010,
        S_LINE = 14'b00000000000100,
        S_MUL  = 14'b00000000001000,
        S_ACC  = 14'b00000000010000,
        S_MAG  = 14'b00000000100000,
        S_CHK  = 14'b00000001000000,
        S_NORM = 14'b00000010000000,
        S_SQI  = 14'b00000100000000,
        S_SQS  = 14'b00001000000000,
        S_DIV  = 14'b00010000000000,
        S_DEND = 14'b00100000000000,
        S_VTX  = 14'b01000000000000,
        S_EMIT = 14'b10000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_newest, n_newest;
    logic [AW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_seg, n_seg;
    logic [3:0]        r_idx, n_idx;
    logic [4:0]        r_step, n_step;
    logic              r_side, n_side;
    logic              r_last, n_last;
    logic [ALONG_W-1:0] r_along, n_along;
    logic [RW-1:0]     r_arem, n_arem;

    logic [AW-1:0]     slot_inc, slot_dec;
    logic [CW-1:0]     cnt_inc;
    logic [RW:0]       arem_sum;

    always_comb begin
        slot_inc = (r_newest == SLOT_TOP) ? '0 : r_newest + 1'b1;
        slot_dec = (r_slot == '0) ? SLOT_TOP : r_slot - 1'b1;
        cnt_inc  = (r_count < CNT_MAX) ? r_count + 1'b1 : r_count;
        arem_sum = {1'b0, r_arem} + {1'b0, STEP_R};
    end

    always_comb begin
        n_state  = r_state;
        n_newest = r_newest;
        n_slot   = r_slot;
        n_count  = r_count;
        n_seg    = r_seg;
        n_idx    = r_idx;
        n_step   = r_step;
        n_side   = r_side;
        n_last   = r_last;
        n_along  = r_along;
        n_arem   = r_arem;
        o_cmd    = '{op: OP_NONE, idx: r_idx, side: r_side};
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_we     = 1'b0;
        o_wzero  = 1'b0;
        o_waddr  = r_newest;
        o_re     = 1'b0;
        o_raddr  = slot_dec;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_we = 1'b1;
                    if (i_in_cmd) begin
                        o_wzero = 1'b1;
                        n_count = CW'(1);
                    end else begin
                        o_waddr   = slot_inc;
                        o_cmd.op  = OP_LOAD;
                        n_newest  = slot_inc;
                        n_slot    = slot_inc;
                        n_count   = cnt_inc;
                        n_seg     = '0;
                        n_along   = '0;
                        n_arem    = '0;
                        n_side    = 1'b0;
                        if (cnt_inc >= CW'(2)) n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_re    = 1'b1;
                n_slot  = slot_dec;
                n_state = S_LINE;
            end
            S_LINE: begin
                o_cmd.op = OP_LINE;
                n_idx    = MI_L1C2;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_idx inside {[MI_DIV_FIRST:MI_DIV_LAST]}) begin
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == MI_L1C0)         n_state = S_MAG;
                    else if (r_idx == MI_SQ_LAST) n_state = S_SQI;
                    else                          n_state = S_MUL;
                end
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.zero) begin
                    o_cmd.op = OP_ZERO;
                    n_state  = S_VTX;
                end else begin
                    n_state  = S_NORM;
                end
            end
            S_NORM: begin
                if (i_sts.norm_ok) n_state = S_MUL;
                else               o_cmd.op = OP_NORM;
            end
            S_SQI: begin
                o_cmd.op = OP_SQINIT;
                n_step   = '0;
                n_state  = S_SQS;
            end
            S_SQS: begin
                o_cmd.op = OP_SQSTEP;
                n_step   = r_step + 1'b1;
                if (r_step == SQRT_LAST_STEP) n_state = S_MUL;
            end
            S_DIV: begin
                o_cmd.op = OP_DIVSTEP;
                n_step   = r_step + 1'b1;
                if (r_step == DIV_LAST_STEP) n_state = S_DEND;
            end
            S_DEND: begin
                o_cmd.op = OP_DIVEND;
                n_idx    = r_idx + 1'b1;
                n_state  = (r_idx == MI_DIV_LAST) ? S_VTX : S_MUL;
            end
            S_VTX: begin
                o_cmd.op = OP_VTX;
                n_last   = r_side & (({1'b0, r_seg} + (CW+1)'(2)) >= {1'b0, r_count});
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_state = S_VTX;
                    end else begin
                        n_side = 1'b0;
                        if (r_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.op = OP_ADV;
                            n_seg    = r_seg + 1'b1;
                            if (arem_sum >= (RW+1)'(MAX_POINTS)) begin
                                n_arem  = RW'(arem_sum - (RW+1)'(MAX_POINTS));
                                n_along = r_along + STEP_Q + 1'b1;
                            end else begin
                                n_arem  = RW'(arem_sum);
                                n_along = r_along + STEP_Q;
                            end
                            n_state = S_RD;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_count  <= '0;
            r_side   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_newest <= n_newest;
            r_count  <= n_count;
            r_side   <= n_side;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_seg   <= n_seg;
        r_idx   <= n_idx;
        r_step  <= n_step;
        r_along <= n_along;
        r_arem  <= n_arem;
    end

    assign o_along = r_along;
    assign o_side  = r_side;
    assign o_last  = r_last;
endmodule
`default_nettype wire

FILE: hw/rtl/ribbon_trail_vertex_gen.sv
// Top level of the camera-facing ribbon trail vertex generator.
// Takes one item at a time. A restart item, and an add item that leaves
// fewer than two points in the history, leaves the block idle and ready
// again in the next cycle. Any other add item walks up to MAX_POINTS-1
// segments, each with the serial square root (31 steps) and the three
// bit-serial divisions (25 steps each) run on one shared 32x32 multiplier
// and two compare-subtract units, one for the root and one for division,
// plus up to ten normalising shift steps, all skipped when the cross
// product is zero; each of its two vertices waits for the output handshake.
// Points live in a MAX_POINTS-entry RAM read one entry per segment; only
// written entries are read, so no clearing pass runs after reset. half_width
// is written through i_cfg_we/i_cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this.
`default_nettype none
module ribbon_trail_vertex_gen import rtv_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    rtv_in_if.sink               i_pt,
    rtv_out_if.source            o_vtx,
    input  wire logic            i_cfg_we,
    input  wire logic [HW_W-1:0] i_cfg_wdata
);
    localparam int AW = $clog2(MAX_POINTS);

    logic [HW_W-1:0]           r_half_width;
    t_dp_cmd                   dp_cmd;
    t_dp_sts                   dp_sts;
    logic                      ram_we, ram_wzero, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [3*COORD_W-1:0]      ram_wdata, ram_rdata;
    logic signed [COORD_W-1:0] pos [3];
    logic signed [COORD_W-1:0] cam [3];
    logic signed [COORD_W-1:0] vert [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_half_width <= HALF_WIDTH_RST;
        else if (i_cfg_we) r_half_width <= i_cfg_wdata;
    end

    assign pos[0] = i_pt.pos_x;
    assign pos[1] = i_pt.pos_y;
    assign pos[2] = i_pt.pos_z;
    assign cam[0] = i_pt.cam_x;
    assign cam[1] = i_pt.cam_y;
    assign cam[2] = i_pt.cam_z;
    // restart puts the origin into the newest slot
    assign ram_wdata = ram_wzero ? '0 : {i_pt.pos_z, i_pt.pos_y, i_pt.pos_x};

    rtv_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .i_in_cmd    (i_pt.cmd),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_vtx.valid),
        .i_out_ready (o_vtx.ready),
        .o_along     (o_vtx.along),
        .o_side      (o_vtx.side),
        .o_last      (o_vtx.last),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_we        (ram_we),
        .o_wzero     (ram_wzero),
        .o_waddr     (ram_waddr),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr)
    );

    rtv_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_POINTS)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rtv_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (dp_cmd),
        .i_half_width (r_half_width),
        .i_pos        (pos),
        .i_cam        (cam),
        .i_rdata      (ram_rdata),
        .o_sts        (dp_sts),
        .o_vert       (vert)
    );

    assign o_vtx.vert_x = vert[0];
    assign o_vtx.vert_y = vert[1];
    assign o_vtx.vert_z = vert[2];
endmodule
`default_nettype wire
